/* rtl/core/sla_pkg.sv */
// Shared types and constants for the sticky least-loaded assigner.
package sla_pkg;

  localparam int KEY_W     = 32;
  localparam int CFG_W     = 4;
  localparam int WIDX_W    = 3;

  typedef enum logic [1:0] {
    ST_OWNED = 2'd0,
    ST_NEW   = 2'd1,
    ST_FULL  = 2'd2
  } assign_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } sla_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } sla_sts_t;

endpackage

/* rtl/core/sla_datapath.sv */
// Datapath: per-worker key banks, owned counts, hit tracking, min search, result register.
module sla_datapath #(
  parameter int MAX_WORKERS      = 8,
  parameter int SLOTS_PER_WORKER = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sla_pkg::sla_cmd_t         cmd,
  output sla_pkg::sla_sts_t         sts,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sla_pkg::CFG_W-1:0] cfg_data,
  input  logic [sla_pkg::KEY_W-1:0] flow_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [sla_pkg::WIDX_W-1:0] worker_index,
  output logic [1:0]                assign_status
);
  import sla_pkg::*;

  localparam int WW       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int UW       = $clog2(MAX_WORKERS + 1);
  localparam int SW       = (SLOTS_PER_WORKER > 1) ? $clog2(SLOTS_PER_WORKER) : 1;
  localparam int CW       = $clog2(SLOTS_PER_WORKER + 1);
  localparam int SCAN_LEN = (SLOTS_PER_WORKER > MAX_WORKERS) ? SLOTS_PER_WORKER : MAX_WORKERS;
  localparam int IW       = $clog2(SCAN_LEN + 1);
  localparam int WC_RST   = (MAX_WORKERS > 15) ? 15 : MAX_WORKERS;

  logic [CFG_W-1:0]       worker_count;
  logic [KEY_W-1:0]       key;
  logic [UW-1:0]          used;
  logic [UW-1:0]          used_in;
  logic [IW-1:0]          idx;
  logic                   rd_en;
  logic                   rd_vld;
  logic [SW-1:0]          rd_slot;
  logic [KEY_W-1:0]       rd_q [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] match;
  logic [MAX_WORKERS-1:0] hit_mask;
  logic                   hit_any;
  logic [WW-1:0]          first_hit;
  logic [WW-1:0]          best;
  logic [CW-1:0]          best_cnt;
  logic [CW-1:0]          cnt [MAX_WORKERS];
  logic [CW-1:0]          cnt_at;
  logic                   wr_en;

  assign cfg_ready = 1'b1;

  // clamp the configured worker count into 1..MAX_WORKERS
  always_comb begin
    if (worker_count == '0) begin
      used_in = UW'(1);
    end else if (int'(worker_count) > MAX_WORKERS) begin
      used_in = UW'(MAX_WORKERS);
    end else begin
      used_in = UW'(worker_count);
    end
  end

  assign rd_en   = cmd.scan && (int'(idx) < SLOTS_PER_WORKER);
  assign hit_any = |hit_mask;
  assign wr_en   = cmd.commit && !hit_any && (int'(best_cnt) < SLOTS_PER_WORKER);
  assign cnt_at  = cnt[idx[WW-1:0]];

  // one bank per worker, all read at the same slot together during the scan
  for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_bank
    logic [KEY_W-1:0] mem [SLOTS_PER_WORKER];

    always_ff @(posedge clk) begin
      if (wr_en && best == WW'(g)) begin
        mem[best_cnt[SW-1:0]] <= key;
      end
      if (rd_en) begin
        rd_q[g] <= mem[idx[SW-1:0]];
      end
    end

    assign match[g] = rd_vld && (CW'(rd_slot) < cnt[g]) && (used > UW'(g)) &&
                      (rd_q[g] == key);
  end

  // lowest worker wins regardless of slot
  always_comb begin
    first_hit = '0;
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (hit_mask[i]) begin
        first_hit = WW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= CFG_W'(WC_RST);
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        worker_count <= cfg_data;
      end
      rd_vld <= rd_en;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        cnt[best] <= best_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= idx[SW-1:0];
    if (cmd.load) begin
      key      <= flow_key;
      used     <= used_in;
      idx      <= '0;
      hit_mask <= '0;
    end else begin
      if (rd_vld) begin
        hit_mask <= hit_mask | match;
      end
      if (cmd.scan) begin
        idx <= idx + IW'(1);
        // least-loaded search runs alongside the slot scan
        if (idx == '0) begin
          best     <= '0;
          best_cnt <= cnt[0];
        end else if ((idx < IW'(used)) && (cnt_at < best_cnt)) begin
          best     <= idx[WW-1:0];
          best_cnt <= cnt_at;
        end
      end
    end
    if (cmd.commit) begin
      if (hit_any) begin
        worker_index  <= WIDX_W'(first_hit);
        assign_status <= ST_OWNED;
      end else if (int'(best_cnt) >= SLOTS_PER_WORKER) begin
        worker_index  <= '0;
        assign_status <= ST_FULL;
      end else begin
        worker_index  <= WIDX_W'(best);
        assign_status <= ST_NEW;
      end
    end
  end

  assign sts.last     = (idx == IW'(SCAN_LEN - 1));
  assign sts.out_busy = out_valid && out_stall;

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result committed over a stalled result");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> cnt[$past(best)] == $past(best_cnt) + CW'(1))
    else $error("owned count not advanced after new assignment");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !cmd.commit) |=> !out_valid)
    else $error("result request repeated after delivery");

endmodule

/* rtl/core/sla_ctrl.sv */
// Controller: sequences accept, slot scan, drain and commit for one request.
module sla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sla_pkg::sla_sts_t  sts,
  output sla_pkg::sla_cmd_t  cmd
);
  import sla_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/sticky_least_loaded_assigner_unit.sv */
// Sticky least-loaded assigner: maps each flow key to the worker that owns it.
//
// Input channel (in_valid / in_stall / flow_key): one request per key. The
// block holds in_stall high from acceptance until the result is committed.
// Output channel (out_valid / out_stall / worker_index / assign_status): one
// result per request, held in an output register while out_stall is high.
// Config channel (cfg_valid / cfg_ready / cfg_data): worker_count, always ready;
// write it only while no request is in flight.
// Sequence: an accept state, a slot scan with its index running up to
// max(SLOTS_PER_WORKER, MAX_WORKERS) - 1, a drain state and a commit state.
// The scan reads one slot of every worker bank per cycle, so that maximum sets
// its length; the least-loaded search walks one worker per cycle alongside it.
// A new request is taken right after commit even while the previous result
// still waits; if the receiver stalls, commit of the next result waits.
// Reset clears the owned counts and the output valid and sets worker_count to
// min(MAX_WORKERS, 15); no clearing pass is needed, the counts gate stored keys.
module sticky_least_loaded_assigner_unit #(
  parameter int MAX_WORKERS      = 8,
  parameter int SLOTS_PER_WORKER = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sla_pkg::KEY_W-1:0]  flow_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sla_pkg::WIDX_W-1:0] worker_index,
  output logic [1:0]                 assign_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sla_pkg::CFG_W-1:0]  cfg_data
);
  import sla_pkg::*;

  sla_cmd_t cmd;
  sla_sts_t sts;

  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sla_datapath #(
    .MAX_WORKERS      (MAX_WORKERS),
    .SLOTS_PER_WORKER (SLOTS_PER_WORKER)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .flow_key      (flow_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .worker_index  (worker_index),
    .assign_status (assign_status)
  );

endmodule
